// ----- src/dftd_pkg.sv -----
// ----------------------------------------------------------------------------
// dftd_pkg
// Shared widths, codes and controller/datapath interface types for the
// differential frequency touch detector.
// ----------------------------------------------------------------------------
package dftd_pkg;

	// low bits of each period word that are used
	localparam int PERIOD_WIDTH = 32;
	localparam int IN_FIELD_W   = 32;
	localparam int IN_DATA_W    = 2 * IN_FIELD_W;

	localparam int CLK_W   = 27;
	localparam int THR_W   = 27;
	localparam int CNT_W   = 16;
	localparam int ALPHA_W = 7;
	localparam int FREQ_W  = 27;
	localparam int DIFF_W  = 28;
	localparam int DELTA_W = 29;
	localparam int OUTC_W  = 3;

	// dividend is timer clock plus half the period
	localparam int NUM_W     = ((PERIOD_WIDTH - 1 > CLK_W) ? PERIOD_WIDTH - 1 : CLK_W) + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	// weighted baseline sum and its divide by 100
	localparam int ACC_W   = 36;
	localparam int Y_W     = 32;
	localparam int RCP_W   = 31;
	localparam int RPROD_W = Y_W + RCP_W;
	// x/100 = (x>>2)/25, and ceil(2^37/25) = 2^32 + RECIP_LO
	localparam logic [RCP_W-1:0] RECIP_LO = 31'd1202590843;
	localparam int RECIP_SHIFT = 5;
	localparam logic [ALPHA_W-1:0] PCT_FULL = 7'd100;

	localparam int OUT_PACK_W = 2 * FREQ_W + 2 * DIFF_W + DELTA_W;
	localparam int OUT_DATA_W = ((OUT_PACK_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 1 + OUTC_W;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 27;

	localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 4'd3;

	localparam logic [CLK_W-1:0]   RST_TIMER_CLOCK = 27'd64000000;
	localparam logic [THR_W-1:0]   RST_THRESHOLD   = 27'd100;
	localparam logic [CNT_W-1:0]   RST_CONFIRM     = 16'd3;
	localparam logic [ALPHA_W-1:0] RST_ALPHA       = 7'd90;

	localparam logic [OUTC_W-1:0] OUTC_REJECTED  = 3'd0;
	localparam logic [OUTC_W-1:0] OUTC_CAPTURED  = 3'd1;
	localparam logic [OUTC_W-1:0] OUTC_ADAPTED   = 3'd2;
	localparam logic [OUTC_W-1:0] OUTC_PENDING   = 3'd3;
	localparam logic [OUTC_W-1:0] OUTC_CONFIRMED = 3'd4;
	localparam logic [OUTC_W-1:0] OUTC_BASE_SET  = 3'd5;

	typedef struct packed {
		logic load_in;
		logic set_base;
		logic reject;
		logic div_start;
		logic div_sel;
		logic store_f1;
		logic store_f2;
		logic eval;
		logic sum;
		logic recip;
		logic fin;
		logic load_out;
	} dftd_cmd_t;

	typedef struct packed {
		logic cmd_bit;
		logic period_zero;
		logic div_done;
		logic base_zero;
		logic over;
	} dftd_stat_t;

endpackage

// ----- src/dftd_div.sv -----
// ----------------------------------------------------------------------------
// dftd_div
// Restoring divider, one quotient bit per cycle, shared by both periods.
// ----------------------------------------------------------------------------
module dftd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dftd_pkg::NUM_W-1:0]  dividend,
	input  logic [dftd_pkg::PERIOD_WIDTH-1:0] divisor,
	output logic                        done,
	output logic [dftd_pkg::NUM_W-1:0]  quotient
);
	import dftd_pkg::*;

	localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(NUM_W - 1);

	logic                    run_q;
	logic                    done_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic [PERIOD_WIDTH-1:0] rem_q;
	logic [PERIOD_WIDTH-1:0] dvs_q;
	logic [NUM_W-1:0]        quo_q;

	logic [PERIOD_WIDTH:0] shifted;
	logic [PERIOD_WIDTH:0] trial;
	logic                  ge;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		trial   = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == LAST);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? trial[PERIOD_WIDTH-1:0] : shifted[PERIOD_WIDTH-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/dftd_datapath.sv -----
// ----------------------------------------------------------------------------
// dftd_datapath
// Configuration registers, frequency and baseline state, threshold test,
// baseline averaging and the output word register.
// ----------------------------------------------------------------------------
module dftd_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [dftd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dftd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [dftd_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	input  dftd_pkg::dftd_cmd_t              cmd,
	output dftd_pkg::dftd_stat_t             stat,
	output logic [dftd_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [dftd_pkg::OUT_USER_W-1:0]  m_tuser
);
	import dftd_pkg::*;

	// configuration
	logic [CLK_W-1:0]   clk_hz_q;
	logic [THR_W-1:0]   thr_q;
	logic [CNT_W-1:0]   confirm_q;
	logic [ALPHA_W-1:0] alpha_q;

	// current item
	logic                    cmd_bit_q;
	logic [PERIOD_WIDTH-1:0] p1_q;
	logic [PERIOD_WIDTH-1:0] p2_q;

	// detector state
	logic [FREQ_W-1:0]        f1_q;
	logic [FREQ_W-1:0]        f2_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [DIFF_W-1:0] base_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [OUTC_W-1:0]        outcome_q;
	logic                     touch_q;

	// averaging pipeline
	logic signed [ACC_W-1:0] prod_a_s1;
	logic signed [ACC_W-1:0] prod_b_s1;
	logic                    neg_s2;
	logic [Y_W-1:0]          y_s2;
	logic                    neg_s3;
	logic [Y_W-1:0]          y_s3;
	logic [RPROD_W-1:0]      prod_r_s3;

	logic [OUT_DATA_W-1:0] tdata_q;
	logic [OUT_USER_W-1:0] tuser_q;

	logic [PERIOD_WIDTH-1:0] period_sel;
	logic [NUM_W-1:0]        dividend;
	logic                    div_done;
	logic [NUM_W-1:0]        quotient;
	logic [FREQ_W-1:0]       freq_new;

	logic [ALPHA_W-1:0]       alpha_eff;
	logic [ALPHA_W-1:0]       beta;
	logic [DELTA_W-1:0]       delta;
	logic [DELTA_W-1:0]       delta_mag;
	logic                     over;
	logic [CNT_W-1:0]         cnt_inc;
	logic                     confirmed;
	logic signed [ACC_W-1:0]  acc;
	logic [ACC_W-1:0]         acc_mag;
	logic [Y_W:0]             hi_sum;
	logic [DIFF_W-1:0]        q_avg;

	always_comb begin
		period_sel = cmd.div_sel ? p2_q : p1_q;
		dividend   = NUM_W'(clk_hz_q) + NUM_W'(period_sel >> 1);
		freq_new   = quotient[FREQ_W-1:0];

		alpha_eff = (alpha_q > PCT_FULL) ? PCT_FULL : alpha_q;
		beta      = PCT_FULL - alpha_eff;

		delta     = {diff_q[DIFF_W-1], diff_q} - {base_q[DIFF_W-1], base_q};
		delta_mag = delta[DELTA_W-1] ? -delta : delta;
		over      = delta_mag > DELTA_W'(thr_q);
		cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
		confirmed = cnt_inc >= confirm_q;

		acc     = prod_a_s1 + prod_b_s1;
		acc_mag = acc[ACC_W-1] ? -acc : acc;

		// floor(y * (2^32 + RECIP_LO) / 2^37), low product bits never carry
		hi_sum = {1'b0, y_s3} + (Y_W+1)'(prod_r_s3[RPROD_W-1:Y_W]);
		q_avg  = hi_sum[RECIP_SHIFT +: DIFF_W];
	end

	dftd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (period_sel),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q  <= RST_TIMER_CLOCK;
			thr_q     <= RST_THRESHOLD;
			confirm_q <= RST_CONFIRM;
			alpha_q   <= RST_ALPHA;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIMER_CLOCK: clk_hz_q  <= cfg_data[CLK_W-1:0];
				REG_THRESHOLD:   thr_q     <= cfg_data[THR_W-1:0];
				REG_CONFIRM:     confirm_q <= cfg_data[CNT_W-1:0];
				REG_ALPHA:       alpha_q   <= cfg_data[ALPHA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_q      <= '0;
			f2_q      <= '0;
			diff_q    <= '0;
			base_q    <= '0;
			cnt_q     <= '0;
			outcome_q <= OUTC_REJECTED;
			touch_q   <= 1'b0;
		end else begin
			if (cmd.set_base) begin
				base_q    <= diff_q;
				cnt_q     <= '0;
				outcome_q <= OUTC_BASE_SET;
				touch_q   <= 1'b0;
			end else if (cmd.reject) begin
				outcome_q <= OUTC_REJECTED;
				touch_q   <= 1'b0;
			end else if (cmd.store_f1) begin
				f1_q <= freq_new;
			end else if (cmd.store_f2) begin
				f2_q   <= freq_new;
				diff_q <= {1'b0, freq_new} - {1'b0, f1_q};
			end else if (cmd.eval) begin
				if (base_q == '0) begin
					base_q    <= diff_q;
					outcome_q <= OUTC_CAPTURED;
					touch_q   <= 1'b0;
				end else if (over) begin
					cnt_q     <= cnt_inc;
					outcome_q <= confirmed ? OUTC_CONFIRMED : OUTC_PENDING;
					touch_q   <= confirmed;
				end else begin
					cnt_q     <= '0;
					outcome_q <= OUTC_ADAPTED;
					touch_q   <= 1'b0;
				end
			end else if (cmd.fin) begin
				base_q <= neg_s3 ? -q_avg : q_avg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_bit_q <= s_tuser;
			p1_q      <= s_tdata[PERIOD_WIDTH-1:0];
			p2_q      <= s_tdata[IN_FIELD_W +: PERIOD_WIDTH];
		end
		if (cmd.eval) begin
			prod_a_s1 <= base_q * $signed({1'b0, alpha_eff});
			prod_b_s1 <= diff_q * $signed({1'b0, beta});
		end
		if (cmd.sum) begin
			neg_s2 <= acc[ACC_W-1];
			y_s2   <= acc_mag[2 +: Y_W];
		end
		if (cmd.recip) begin
			neg_s3    <= neg_s2;
			y_s3      <= y_s2;
			prod_r_s3 <= y_s2 * RECIP_LO;
		end
		if (cmd.load_out) begin
			tdata_q <= OUT_DATA_W'({delta, base_q, diff_q, f2_q, f1_q});
			tuser_q <= {outcome_q, touch_q};
		end
	end

	always_comb begin
		stat.cmd_bit     = cmd_bit_q;
		stat.period_zero = (p1_q == '0) || (p2_q == '0);
		stat.div_done    = div_done;
		stat.base_zero   = base_q == '0;
		stat.over        = over;
	end

	assign m_tdata = tdata_q;
	assign m_tuser = tuser_q;

endmodule

// ----- src/dftd_ctrl.sv -----
// ----------------------------------------------------------------------------
// dftd_ctrl
// Sequencer: input acceptance, two divisions, evaluation, baseline
// averaging and the output handshake.
// ----------------------------------------------------------------------------
module dftd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  dftd_pkg::dftd_stat_t stat,
	output dftd_pkg::dftd_cmd_t  cmd
);
	import dftd_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DECIDE = 4'd1;
	localparam logic [3:0] ST_DIV1   = 4'd2;
	localparam logic [3:0] ST_DIV2   = 4'd3;
	localparam logic [3:0] ST_EVAL   = 4'd4;
	localparam logic [3:0] ST_SUM    = 4'd5;
	localparam logic [3:0] ST_RECIP  = 4'd6;
	localparam logic [3:0] ST_FIN    = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       m_tvalid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.cmd_bit) begin
					cmd.set_base = 1'b1;
					state_nxt    = ST_OUT;
				end else if (stat.period_zero) begin
					cmd.reject = 1'b1;
					state_nxt  = ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (stat.div_done) begin
					cmd.store_f1  = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = 1'b1;
					state_nxt     = ST_DIV2;
				end
			end
			ST_DIV2: begin
				cmd.div_sel = 1'b1;
				if (stat.div_done) begin
					cmd.store_f2 = 1'b1;
					state_nxt    = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = (stat.base_zero || stat.over) ? ST_OUT : ST_SUM;
			end
			ST_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = ST_RECIP;
			end
			ST_RECIP: begin
				cmd.recip = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin   = 1'b1;
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;

endmodule

// ----- src/differential_frequency_touch_detector.sv -----
// ----------------------------------------------------------------------------
// differential_frequency_touch_detector
// Converts two oscillator periods to frequencies, tracks their difference
// against an adaptive baseline and confirms touches.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per sample: two periods in timer ticks in tdata,
//   tuser set for a baseline-set command instead of a sample.
//   m_* returns one word per input word: touch and outcome in tuser, both
//   frequencies, difference, baseline and deviation in tdata.
//   cfg_* writes the four settings by index; always ready, write only
//   while no word is in flight.
// Flow: a command or a zero period goes to the output register after the
//   decision; a sample first passes both divisions and evaluation, plus
//   the averaging steps when the baseline is averaged. One word at a time:
//   the next word is accepted once the last result is loaded into the
//   output register. The shared divider produces one quotient bit per cycle.
// Reset clears the sequencer and detector state and loads the default settings; data registers are not reset.
// While the receiver stalls, the result holds in the output register; the
//   next word is still accepted and processed, then waits for that register.
// ----------------------------------------------------------------------------
module differential_frequency_touch_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dftd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dftd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// period_first, period_second
	input  logic [dftd_pkg::IN_DATA_W-1:0]   s_tdata,
	// command
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// freq_first_hz, freq_second_hz, diff_hz, baseline_out_hz, deviation_hz
	output logic [dftd_pkg::OUT_DATA_W-1:0]  m_tdata,
	// touch, outcome
	output logic [dftd_pkg::OUT_USER_W-1:0]  m_tuser
);
	import dftd_pkg::*;

	dftd_cmd_t  cmd;
	dftd_stat_t stat;

	assign cfg_ready = 1'b1;

	dftd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dftd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ----- src/dftd_chk.sv -----
// ----------------------------------------------------------------------------
// dftd_chk
// Port-level checks for the touch detector, bound to the top level.
// ----------------------------------------------------------------------------
module dftd_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [dftd_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [dftd_pkg::OUT_USER_W-1:0]  m_tuser
);
	import dftd_pkg::*;

	// one word in flight: no second accept right after the first
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted twice in a row");

	// a result never appears the cycle after an accept
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output word changed");

	a_touch_confirmed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tuser[3:1] == OUTC_CONFIRMED))
		else $error("touch without confirmed outcome");

	// deviation field matches difference minus baseline
	a_delta: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[138:110] ==
			DELTA_W'({m_tdata[81], m_tdata[81:54]} - {m_tdata[109], m_tdata[109:82]})))
		else $error("deviation inconsistent with difference and baseline");

endmodule

bind differential_frequency_touch_detector dftd_chk u_dftd_chk (.*);
